### design/sbq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_pkg
// Shared types, codes and the microcode table of the subleq core.
// ----------------------------------------------------------------------------
package sbq_pkg;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_EXEC    = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  // instruction word layout
  localparam int unsigned FIELD_A_HI = 31;
  localparam int unsigned FIELD_A_LO = 22;
  localparam int unsigned FIELD_B_HI = 21;
  localparam int unsigned FIELD_B_LO = 12;
  localparam int unsigned FIELD_C_HI = 11;
  localparam int unsigned FIELD_C_LO = 2;
  localparam int unsigned HALT_BIT   = 0;

  // microcode step numbers
  typedef logic [3:0] step_t;

  localparam step_t ST_WRITE   = 4'd0;
  localparam step_t ST_READ0   = 4'd1;
  localparam step_t ST_READ1   = 4'd2;
  localparam step_t ST_FETCH   = 4'd3;
  localparam step_t ST_DECODE  = 4'd4;
  localparam step_t ST_OPER_B  = 4'd5;
  localparam step_t ST_WBACK   = 4'd6;
  localparam step_t ST_HALT    = 4'd7;
  localparam step_t ST_RESTART = 4'd8;

  // memory address source
  typedef enum logic [1:0] {
    ADDR_IN,
    ADDR_PC,
    ADDR_A,
    ADDR_B
  } addr_sel_e;

  // memory write data source
  typedef enum logic {
    WD_IN,
    WD_DIFF
  } wd_sel_e;

  // result data source
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_MEM,
    RES_DIFF
  } res_sel_e;

  // program counter update
  typedef enum logic [1:0] {
    PC_HOLD,
    PC_CLEAR,
    PC_BRANCH
  } pc_op_e;

  // one control word
  typedef struct packed {
    logic      rd_en;
    logic      wr_en;
    addr_sel_e addr_sel;
    wd_sel_e   wd_sel;
    logic      latch_inst;
    logic      latch_opa;
    logic      jmp_halt;
    step_t     jmp_target;
    logic      done;
    res_sel_e  res_sel;
    pc_op_e    pc_op;
    logic      halt_flag;
  } ctrl_t;

  localparam ctrl_t CTRL_IDLE = '{
    rd_en: 1'b0, wr_en: 1'b0, addr_sel: ADDR_IN, wd_sel: WD_IN,
    latch_inst: 1'b0, latch_opa: 1'b0, jmp_halt: 1'b0, jmp_target: ST_WRITE,
    done: 1'b0, res_sel: RES_ZERO, pc_op: PC_HOLD, halt_flag: 1'b0
  };

  // first step of each operation
  function automatic step_t entry_step(input logic [1:0] op);
    step_t s;
    case (op)
      OP_WRITE: s = ST_WRITE;
      OP_READ:  s = ST_READ0;
      OP_EXEC:  s = ST_FETCH;
      default:  s = ST_RESTART;
    endcase
    return s;
  endfunction

  // microcode table
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c = CTRL_IDLE;
    case (s)
      ST_WRITE: begin
        c.wr_en = 1'b1;
        c.done  = 1'b1;
      end
      ST_READ0: begin
        c.rd_en = 1'b1;
      end
      ST_READ1: begin
        c.done    = 1'b1;
        c.res_sel = RES_MEM;
      end
      ST_FETCH: begin
        c.rd_en    = 1'b1;
        c.addr_sel = ADDR_PC;
      end
      ST_DECODE: begin
        c.rd_en      = 1'b1;
        c.addr_sel   = ADDR_A;
        c.latch_inst = 1'b1;
        c.jmp_halt   = 1'b1;
        c.jmp_target = ST_HALT;
      end
      ST_OPER_B: begin
        c.rd_en     = 1'b1;
        c.addr_sel  = ADDR_B;
        c.latch_opa = 1'b1;
      end
      ST_WBACK: begin
        c.wr_en    = 1'b1;
        c.addr_sel = ADDR_B;
        c.wd_sel   = WD_DIFF;
        c.done     = 1'b1;
        c.res_sel  = RES_DIFF;
        c.pc_op    = PC_BRANCH;
      end
      ST_HALT: begin
        c.done      = 1'b1;
        c.halt_flag = 1'b1;
      end
      ST_RESTART: begin
        c.done  = 1'b1;
        c.pc_op = PC_CLEAR;
      end
      default: begin
        c.done = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### design/sbq_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_sequencer
// Step counter over the microcode table: picks the entry step of an accepted
// item, steps or jumps on the halt bit, and ends the item on a done step.
// ----------------------------------------------------------------------------
module sbq_sequencer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire logic [1:0]    operation_i,
  input  wire logic          halt_i,
  output logic               busy_o,
  output sbq_pkg::ctrl_t     ctrl_o
);
  import sbq_pkg::*;

  logic  busy_q, busy_d;
  step_t upc_q, upc_d;
  step_t step;
  logic  active;

  // current step: entry of a new item or the stored step
  always_comb begin
    active = busy_q | start;
    step   = busy_q ? upc_q : entry_step(operation_i);
    ctrl_o = active ? ucode(step) : CTRL_IDLE;
  end

  // next step
  always_comb begin
    busy_d = active & ~ctrl_o.done;
    upc_d  = upc_q;
    if (active) begin
      if (ctrl_o.jmp_halt && halt_i) begin
        upc_d = ctrl_o.jmp_target;
      end else begin
        upc_d = step + step_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= ST_WRITE;
    end else begin
      busy_q <= busy_d;
      upc_q  <= upc_d;
    end
  end

  assign busy_o = busy_q;

endmodule
`default_nettype wire

### design/subleq_processor_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// subleq_processor_core
// SUBLEQ core with a local word memory, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result shows
// on done_o for a single cycle and cannot be held off. Through the single memory
// port, write and restart end in their entry step, a read reads then reports,
// a halting execute fetches, decodes and reports, and an execute fetches,
// reads a, reads b and writes back. Memory words are undefined until written.
// base_address may only change while idle.
module subleq_processor_core #(
  parameter int unsigned ADDR_BITS = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        base_address_we_i,
  input  wire logic [9:0]  base_address_i,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation_i,
  input  wire logic [9:0]  address_i,
  input  wire logic [31:0] write_data_i,
  output logic             done_o,
  output logic [31:0]      read_data_o,
  output logic [9:0]       program_counter_o,
  output logic             halted_o
);
  import sbq_pkg::*;

  localparam int unsigned MemWords = 1 << ADDR_BITS;

  ctrl_t ctrl;

  logic [31:0]          mem [MemWords];
  logic [31:0]          rd_q;
  logic [31:0]          inst_q;
  logic [31:0]          opa_q;
  logic [9:0]           base_q;
  logic [ADDR_BITS-1:0] pc_q, pc_d;
  logic                 done_q;
  logic                 halted_q;
  logic [31:0]          read_data_q, read_data_d;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [31:0]          mem_wdata;
  logic [31:0]          diff;
  logic                 take_branch;

  // base offset plus relative address, wrapped at memory size
  function automatic logic [ADDR_BITS-1:0] phys(input logic [9:0] base,
                                                input logic [ADDR_BITS-1:0] rel);
    logic [ADDR_BITS+10:0] sum;
    sum = {{(ADDR_BITS+1){1'b0}}, base} + {11'b0, rel};
    return sum[ADDR_BITS-1:0];
  endfunction

  sbq_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .halt_i      (rd_q[HALT_BIT]),
    .busy_o      (busy),
    .ctrl_o      (ctrl)
  );

  // base address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (base_address_we_i) begin
      base_q <= base_address_i;
    end
  end

  // memory address and write data
  always_comb begin
    case (ctrl.addr_sel)
      ADDR_IN: mem_addr = ADDR_BITS'(address_i);
      ADDR_PC: mem_addr = phys(base_q, pc_q);
      ADDR_A:  mem_addr = phys(base_q, ADDR_BITS'(rd_q[FIELD_A_HI:FIELD_A_LO]));
      ADDR_B:  mem_addr = phys(base_q, ADDR_BITS'(inst_q[FIELD_B_HI:FIELD_B_LO]));
      default: mem_addr = '0;
    endcase
    mem_wdata = (ctrl.wd_sel == WD_DIFF) ? diff : write_data_i;
  end

  // word memory, registered read
  always_ff @(posedge clk_i) begin
    if (ctrl.wr_en) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (ctrl.rd_en) begin
      rd_q <= mem[mem_addr];
    end
  end

  // instruction and operand a holding registers
  always_ff @(posedge clk_i) begin
    if (ctrl.latch_inst) begin
      inst_q <= rd_q;
    end
    if (ctrl.latch_opa) begin
      opa_q <= rd_q;
    end
  end

  // subtract and branch decision
  assign diff        = rd_q - opa_q;
  assign take_branch = (diff == '0) || diff[31];

  // next pc and result data
  always_comb begin
    case (ctrl.pc_op)
      PC_HOLD:   pc_d = pc_q;
      PC_CLEAR:  pc_d = '0;
      PC_BRANCH: pc_d = take_branch ? ADDR_BITS'(inst_q[FIELD_C_HI:FIELD_C_LO])
                                    : pc_q + ADDR_BITS'(1);
      default:   pc_d = pc_q;
    endcase
    case (ctrl.res_sel)
      RES_ZERO: read_data_d = '0;
      RES_MEM:  read_data_d = rd_q;
      RES_DIFF: read_data_d = diff;
      default:  read_data_d = '0;
    endcase
  end

  // pc and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      done_q   <= 1'b0;
      halted_q <= 1'b0;
    end else begin
      pc_q     <= pc_d;
      done_q   <= ctrl.done;
      halted_q <= ctrl.halt_flag;
    end
  end

  // result data
  always_ff @(posedge clk_i) begin
    if (ctrl.done) begin
      read_data_q <= read_data_d;
    end
  end

  assign done_o            = done_q;
  assign read_data_o       = read_data_q;
  assign program_counter_o = 10'(pc_q);
  assign halted_o          = halted_q;

  // a result never shows while an item is still in progress
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_o && busy))
    else $error("result strobe while busy");

  // single-step items report in the next cycle
  a_short_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (operation_i == OP_WRITE || operation_i == OP_RESTART))
    |=> done_o)
    else $error("write or restart did not complete in one cycle");

  // a halting execute reports zero data and keeps the pc
  a_halt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && halted_o) |-> (read_data_o == '0))
    else $error("halted result with nonzero data");

  a_halt_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && halted_o) |-> $stable(program_counter_o))
    else $error("pc changed on halt");

  // restart clears the pc
  a_restart_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i == OP_RESTART) |=> (program_counter_o == '0))
    else $error("restart did not clear pc");

endmodule
`default_nettype wire

### test/subleq_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// subleq_result_checker
// Shadow model and result comparison for the subleq core. It watches the
// register port, the item channel and the result strobe, keeps its own copy of
// memory, pc and base, and compares every result field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module subleq_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_base_i,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  op_i,
  input  logic [9:0]  addr_i,
  input  logic [31:0] wdata_i,
  input  logic        done_i,
  input  logic [31:0] rdata_i,
  input  logic [9:0]  pc_i,
  input  logic        halted_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  import sbq_pkg::*;

  localparam int unsigned MemWords = 1024;

  typedef struct packed {
    logic [31:0] data;
    logic [9:0]  pc;
    logic        halted;
  } core_result_t;

  // shadow state of the core
  logic [31:0]  shadow_mem [MemWords];
  logic [9:0]   shadow_pc;
  logic [9:0]   shadow_base;
  core_result_t predicted_results [$];

  // scratch for one prediction
  core_result_t want;
  logic [31:0]  inst_word;
  logic [31:0]  diff;
  logic [9:0]   fetch_addr;
  logic [9:0]   addr_a;
  logic [9:0]   addr_b;

  task automatic check_field(input string field, input logic [31:0] expected,
                             input logic [31:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected 0x%h, actual 0x%h",
               $time, field, expected, actual);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_pc    = '0;
      shadow_base  = '0;
      predicted_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      // base register write
      if (cfg_we_i) begin
        shadow_base = cfg_base_i;
      end

      // accepted item: step the shadow core and queue its result
      if (start_i && !busy_i) begin
        want = '0;
        case (op_e'(op_i))
          OP_WRITE: begin
            shadow_mem[addr_i] = wdata_i;
          end
          OP_READ: begin
            want.data = shadow_mem[addr_i];
          end
          OP_EXEC: begin
            fetch_addr = shadow_base + shadow_pc;
            inst_word  = shadow_mem[fetch_addr];
            if (inst_word[HALT_BIT]) begin
              want.halted = 1'b1;
            end else begin
              addr_a = shadow_base + inst_word[FIELD_A_HI:FIELD_A_LO];
              addr_b = shadow_base + inst_word[FIELD_B_HI:FIELD_B_LO];
              diff   = shadow_mem[addr_b] - shadow_mem[addr_a];
              shadow_mem[addr_b] = diff;
              want.data = diff;
              // branch when the signed result is zero or negative
              if (diff == '0 || diff[31]) begin
                shadow_pc = inst_word[FIELD_C_HI:FIELD_C_LO];
              end else begin
                shadow_pc = shadow_pc + 10'd1;
              end
            end
          end
          default: begin
            shadow_pc = '0;
          end
        endcase
        want.pc = shadow_pc;
        predicted_results.push_back(want);
      end

      // result strobe: compare with the oldest prediction
      if (done_i) begin
        checked_o++;
        if (predicted_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual data 0x%h pc 0x%h halted %b",
                   $time, rdata_i, pc_i, halted_i);
          fail_count_o++;
        end else begin
          want = predicted_results.pop_front();
          check_field("read_data", want.data, rdata_i);
          check_field("program_counter", 32'(want.pc), 32'(pc_i));
          check_field("halted", 32'(want.halted), 32'(halted_i));
        end
      end

      pending_o = predicted_results.size();
    end
  end

endmodule

### test/tb_subleq_processor_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_subleq_processor_core
// Stimulus and verdict for the subleq core. A directed program at the top
// base covers every operation, wrap of pc and addresses, zero, negative,
// positive and most-negative results, and halting words. Random phases then
// load small programs at varied bases (never touching an unloaded word) and
// run them with reads, writes and restarts mixed in, with random idle gaps.
// ----------------------------------------------------------------------------
module tb_subleq_processor_core;
  import sbq_pkg::*;

  localparam int ItemTarget = 815;
  localparam int TimeoutNs  = 1_000_000;

  // core ports
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        base_address_we_i;
  logic [9:0]  base_address_i;
  logic        start;
  logic        busy;
  logic [1:0]  operation_i;
  logic [9:0]  address_i;
  logic [31:0] write_data_i;
  logic        done_o;
  logic [31:0] read_data_o;
  logic [9:0]  program_counter_o;
  logic        halted_o;

  // checker status
  int fail_total;
  int pending_total;
  int checked_total;

  // stimulus bookkeeping
  logic [1023:0] written_map;
  logic [9:0]    written_q [$];
  logic [1023:0] slot_map;
  logic [9:0]    slot_q [$];
  logic [9:0]    data_q [$];
  logic [9:0]    base_now;
  int            items_total;
  int            op_count [4];
  int            base_writes;
  int            programs;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  subleq_processor_core #(
    .ADDR_BITS(10)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .base_address_we_i (base_address_we_i),
    .base_address_i    (base_address_i),
    .start             (start),
    .busy              (busy),
    .operation_i       (operation_i),
    .address_i         (address_i),
    .write_data_i      (write_data_i),
    .done_o            (done_o),
    .read_data_o       (read_data_o),
    .program_counter_o (program_counter_o),
    .halted_o          (halted_o)
  );

  subleq_result_checker subleq_watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (base_address_we_i),
    .cfg_base_i   (base_address_i),
    .start_i      (start),
    .busy_i       (busy),
    .op_i         (operation_i),
    .addr_i       (address_i),
    .wdata_i      (write_data_i),
    .done_i       (done_o),
    .rdata_i      (read_data_o),
    .pc_i         (program_counter_o),
    .halted_i     (halted_o),
    .fail_count_o (fail_total),
    .pending_o    (pending_total),
    .checked_o    (checked_total)
  );

  function automatic logic [9:0] to_phys(input logic [9:0] rel);
    return base_now + rel;
  endfunction

  function automatic logic [31:0] encode_inst(input logic [9:0] a_rel, input logic [9:0] b_rel,
                                              input logic [9:0] c_rel, input logic spare);
    logic [31:0] w;
    w = '0;
    w[FIELD_A_HI:FIELD_A_LO] = a_rel;
    w[FIELD_B_HI:FIELD_B_LO] = b_rel;
    w[FIELD_C_HI:FIELD_C_LO] = c_rel;
    w[1] = spare;
    return w;
  endfunction

  function automatic logic [9:0] pick_written();
    return written_q[$urandom_range(written_q.size() - 1)];
  endfunction

  // data word biased toward the sign and zero boundaries
  function automatic logic [31:0] data_word();
    case ($urandom_range(11))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // slot instruction; halts where fall-through would leave the program, or at random
  function automatic logic [31:0] make_instruction(input logic [9:0] rel);
    logic [31:0] w;
    logic [9:0]  next_rel;
    logic [9:0]  a_rel;
    logic [9:0]  b_rel;
    next_rel = rel + 10'd1;
    if (!slot_map[next_rel] || $urandom_range(9) == 0) begin
      w = $urandom;
      w[HALT_BIT] = 1'b1;
    end else begin
      b_rel = data_q[$urandom_range(data_q.size() - 1)];
      a_rel = pick_written() - base_now;
      if ($urandom_range(3) == 0) begin
        a_rel = b_rel;
      end
      w = encode_inst(a_rel, b_rel, slot_q[$urandom_range(slot_q.size() - 1)],
                      1'($urandom_range(1)));
    end
    return w;
  endfunction

  // drive one item and wait until the core takes it
  task automatic send_item(input op_e op, input logic [9:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    if (!(items_total >= 300 && items_total < 450) && $urandom_range(99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start        <= 1'b1;
    operation_i  <= op;
    address_i    <= addr;
    write_data_i <= data;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_total++;
    op_count[op]++;
    if (op == OP_WRITE && !written_map[addr]) begin
      written_map[addr] = 1'b1;
      written_q.push_back(addr);
    end
  endtask

  // drop start and wait until every result is back and the core is free
  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_total != 0 || busy) @(negedge clk_i);
  endtask

  task automatic write_base(input logic [9:0] value);
    wait_idle();
    base_address_we_i <= 1'b1;
    base_address_i    <= value;
    @(negedge clk_i);
    base_address_we_i <= 1'b0;
    base_now = value;
    base_writes++;
  endtask

  // run limit
  initial begin
    #(TimeoutNs);
    $display("%0t: timeout with %0d results outstanding", $time, pending_total);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [9:0]    rel;
    logic [9:0]    addr;
    logic [9:0]    new_base;
    logic [1023:0] data_map;
    int            sel;
    int            n_body;
    int            n_data;
    int            n_extra;
    int            seg_start [3];
    int            seg_len [3];

    rst_ni            = 1'b0;
    base_address_we_i = 1'b0;
    base_address_i    = '0;
    start             = 1'b0;
    operation_i       = OP_WRITE;
    address_i         = '0;
    write_data_i      = '0;
    written_map       = '0;
    slot_map          = '0;
    base_now          = '0;
    items_total       = 0;
    base_writes       = 0;
    programs          = 0;
    foreach (op_count[i]) op_count[i] = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed program at the top base so program and data wrap the memory end
    write_base(10'd1023);
    send_item(OP_WRITE, to_phys(10'd10), 32'd5);
    send_item(OP_WRITE, to_phys(10'd11), 32'd3);
    send_item(OP_WRITE, to_phys(10'd12), 32'h8000_0000);
    send_item(OP_WRITE, to_phys(10'd14), 32'h0000_0000);
    send_item(OP_WRITE, to_phys(10'd16), 32'h7fff_ffff);
    // positive result, fall through
    send_item(OP_WRITE, to_phys(10'd0), encode_inst(10'd11, 10'd10, 10'd3, 1'b0));
    // zero result, branch
    send_item(OP_WRITE, to_phys(10'd1), encode_inst(10'd10, 10'd10, 10'd2, 1'b0));
    // most negative result, branch to the last pc
    send_item(OP_WRITE, to_phys(10'd2), encode_inst(10'd14, 10'd12, 10'd1023, 1'b0));
    // largest positive result, pc wraps to zero
    send_item(OP_WRITE, to_phys(10'd1023), encode_inst(10'd14, 10'd16, 10'd3, 1'b0));
    // halting word with every bit set
    send_item(OP_WRITE, to_phys(10'd3), 32'hffff_ffff);
    send_item(OP_RESTART, 10'd0, 32'd0);
    repeat (7) send_item(OP_EXEC, 10'($urandom), $urandom);
    send_item(OP_RESTART, 10'h3ff, 32'hffff_ffff);
    send_item(OP_READ, to_phys(10'd10), 32'd0);
    send_item(OP_READ, 10'd1023, 32'd0);
    send_item(OP_READ, 10'd0, 32'hffff_ffff);

    // random programs, each under its own base
    while (items_total < ItemTarget) begin
      sel = $urandom_range(9);
      if (programs == 0 || sel == 0) begin
        new_base = 10'd0;
      end else if (sel == 1) begin
        new_base = 10'd1023;
      end else begin
        new_base = 10'($urandom);
      end
      write_base(new_base);

      // program slots: a segment at pc zero plus up to two elsewhere, some at the wrap
      slot_map = '0;
      data_map = '0;
      slot_q.delete();
      data_q.delete();
      n_extra = $urandom_range(0, 2);
      seg_start[0] = 0;
      seg_len[0]   = $urandom_range(1, 6);
      for (int s = 1; s <= n_extra; s++) begin
        seg_start[s] = ($urandom_range(3) == 0) ? 1020 + $urandom_range(3) :
                                                  $urandom_range(1023);
        seg_len[s]   = $urandom_range(1, 4);
      end
      for (int s = 0; s <= n_extra; s++) begin
        for (int k = 0; k <= seg_len[s]; k++) begin
          rel = 10'(seg_start[s] + k);
          if (!slot_map[rel]) begin
            slot_map[rel] = 1'b1;
            slot_q.push_back(rel);
          end
        end
      end
      // data words anywhere outside the program
      n_data = $urandom_range(2, 6);
      while (data_q.size() < n_data) begin
        rel = 10'($urandom);
        if (!slot_map[rel] && !data_map[rel]) begin
          data_map[rel] = 1'b1;
          data_q.push_back(rel);
        end
      end

      // load data, then code, then start from pc zero
      foreach (data_q[i]) send_item(OP_WRITE, to_phys(data_q[i]), data_word());
      foreach (slot_q[i]) send_item(OP_WRITE, to_phys(slot_q[i]), make_instruction(slot_q[i]));
      send_item(OP_RESTART, 10'($urandom), $urandom);
      programs++;

      // run the program with other traffic mixed in
      n_body = $urandom_range(30, 70);
      repeat (n_body) begin
        sel = $urandom_range(99);
        if (sel < 72) begin
          send_item(OP_EXEC, 10'($urandom), $urandom);
        end else if (sel < 80) begin
          send_item(OP_READ, pick_written(), $urandom);
        end else if (sel < 88) begin
          send_item(OP_WRITE, to_phys(data_q[$urandom_range(data_q.size() - 1)]), data_word());
        end else if (sel < 92) begin
          // stray write; a program slot only ever gets a valid instruction
          addr = 10'($urandom);
          rel  = addr - base_now;
          send_item(OP_WRITE, addr, slot_map[rel] ? make_instruction(rel) : data_word());
        end else if (sel < 97) begin
          send_item(OP_RESTART, 10'($urandom), $urandom);
        end else begin
          rel = slot_q[$urandom_range(slot_q.size() - 1)];
          send_item(OP_WRITE, to_phys(rel), make_instruction(rel));
        end
      end
    end

    // drain and verdict
    wait_idle();
    repeat (8) @(negedge clk_i);
    $display("covered %0d items: %0d writes, %0d reads, %0d executes, %0d restarts",
             items_total, op_count[OP_WRITE], op_count[OP_READ], op_count[OP_EXEC],
             op_count[OP_RESTART]);
    $display("%0d programs under %0d base settings, %0d results compared",
             programs, base_writes, checked_total);
    if (fail_total == 0 && pending_total == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/sbq_pkg.sv
design/sbq_sequencer.sv
design/subleq_processor_core.sv
test/subleq_result_checker.sv
test/tb_subleq_processor_core.sv
